// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/rrc_pkg.sv =====
package rrc_pkg;

    localparam int GEN_BITS = 8;

    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT_TICKS = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RETRY_LIMIT = 1'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [3:0] RETRY_LIMIT_RESET = 4'd3;
    localparam logic [15:0] SILENCE_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_FRAME = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_FAILED = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic tx_accept;
        logic clear_list;
        logic [7:0] frame_total;
        logic [7:0] frame_seq;
    } t_in_word;

    typedef struct packed {
        logic query_issued;
        logic [1:0] sync_status;
        logic list_complete;
        logic [3:0] retries_used;
        logic fail_pulse;
    } t_out_word;

endpackage

// ===== sv/resync_retry_controller_core.sv =====
// List resync controller with timeout and retry. One input word is taken
// per clock cycle; its result word appears in the output register on the
// next cycle unless the output stalls. All state updates for a word are done
// by the flag and counter logic between the input handshake and the output
// register, so the rate is one word per cycle. A one-word skid register
// behind the output register keeps input flowing for one more word while the
// output side stalls; the input stalls only while the skid register is full.
// Configuration writes take effect on the cycle after the write enable.
module resync_retry_controller_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  rrc_pkg::t_in_word                     i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output rrc_pkg::t_out_word                    o_out_word,
    input  logic                                  i_cfg_we,
    input  logic [rrc_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [rrc_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import rrc_pkg::*;

    `include "assert_macros.svh"

    logic [15:0]         r_timeout;
    logic [3:0]          r_limit;

    logic                r_pending;
    logic                r_awaiting;
    logic                r_failed;
    logic [3:0]          r_retry;
    logic [GEN_BITS-1:0] r_req_gen;
    logic [GEN_BITS-1:0] r_query_gen;
    logic [15:0]         r_silence;
    logic                r_complete;

    logic                n_pending;
    logic                n_awaiting;
    logic                n_failed;
    logic [3:0]          n_retry;
    logic [GEN_BITS-1:0] n_req_gen;
    logic [GEN_BITS-1:0] n_query_gen;
    logic [15:0]         n_silence;
    logic                n_complete;
    logic                n_issued;
    logic                n_fail;

    logic                r_out_valid;
    t_out_word           r_out_word;
    logic                r_skid_valid;
    t_out_word           r_skid_word;

    t_out_word           n_word;
    logic                in_acc;
    logic                out_take;
    logic [15:0]         sil_inc;
    logic                frame_done;

    assign in_acc = i_in_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word = r_out_word;

    always_comb begin
        n_pending = r_pending;
        n_awaiting = r_awaiting;
        n_failed = r_failed;
        n_retry = r_retry;
        n_req_gen = r_req_gen;
        n_query_gen = r_query_gen;
        n_silence = r_silence;
        n_complete = r_complete;
        n_issued = 1'b0;
        n_fail = 1'b0;
        sil_inc = (r_silence != SILENCE_MAX) ? r_silence + 16'd1 : r_silence;
        frame_done = r_complete;
        if (i_in_word.frame_total == 8'd0) begin
            frame_done = 1'b1;
        end else begin
            if (i_in_word.frame_seq == 8'd1) begin
                frame_done = 1'b0;
            end
            if (i_in_word.frame_seq >= i_in_word.frame_total) begin
                frame_done = 1'b1;
            end
        end
        case (t_cmd'(i_in_word.cmd))
            CMD_TICK: begin
                if (r_awaiting) begin
                    n_silence = sil_inc;
                    if (sil_inc >= r_timeout) begin
                        n_awaiting = 1'b0;
                        if (r_retry >= r_limit) begin
                            n_pending = 1'b0;
                            n_failed = 1'b1;
                            n_retry = 4'd0;
                            n_fail = 1'b1;
                        end else begin
                            n_retry = r_retry + 4'd1;
                            if (i_in_word.tx_accept) begin
                                n_awaiting = 1'b1;
                                n_query_gen = r_req_gen;
                                n_silence = 16'd0;
                                n_issued = 1'b1;
                            end
                        end
                    end
                end else if (r_pending) begin
                    n_retry = 4'd0;
                    if (i_in_word.tx_accept) begin
                        n_awaiting = 1'b1;
                        n_query_gen = r_req_gen;
                        n_silence = 16'd0;
                        n_issued = 1'b1;
                    end
                end
            end
            CMD_REQUEST: begin
                n_pending = 1'b1;
                n_failed = 1'b0;
                n_req_gen = r_req_gen + GEN_BITS'(1);
                if (i_in_word.clear_list) begin
                    n_complete = 1'b0;
                end
            end
            CMD_FRAME: begin
                n_complete = frame_done;
                if (r_awaiting) begin
                    n_silence = 16'd0;
                    if (frame_done) begin
                        n_awaiting = 1'b0;
                        n_failed = 1'b0;
                        n_retry = 4'd0;
                        if (r_query_gen == r_req_gen) begin
                            n_pending = 1'b0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        n_word.query_issued = n_issued;
        n_word.sync_status = n_failed ? ST_FAILED :
                             ((n_awaiting || n_pending) ? ST_BUSY : ST_IDLE);
        n_word.list_complete = n_complete;
        n_word.retries_used = n_retry;
        n_word.fail_pulse = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_limit <= RETRY_LIMIT_RESET;
            r_pending <= 1'b0;
            r_awaiting <= 1'b0;
            r_failed <= 1'b0;
            r_retry <= 4'd0;
            r_req_gen <= '0;
            r_query_gen <= '0;
            r_silence <= 16'd0;
            r_complete <= 1'b0;
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TIMEOUT_TICKS: r_timeout <= i_cfg_data;
                    REG_RETRY_LIMIT: r_limit <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (in_acc) begin
                r_pending <= n_pending;
                r_awaiting <= n_awaiting;
                r_failed <= n_failed;
                r_retry <= n_retry;
                r_req_gen <= n_req_gen;
                r_query_gen <= n_query_gen;
                r_silence <= n_silence;
                r_complete <= n_complete;
            end
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out_word <= r_skid_word;
                    r_out_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else if (in_acc) begin
                    r_out_word <= n_word;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (in_acc) begin
                r_skid_word <= n_word;
                r_skid_valid <= 1'b1;
            end
        end
    end

    `ASSERT_IMPL(a_fail_status, r_out_valid && r_out_word.fail_pulse,
        r_out_word.sync_status == ST_FAILED, "fail pulse without failed status")
    `ASSERT_NEXT(a_issue_waits, in_acc && n_issued,
        r_awaiting && (r_query_gen == $past(r_req_gen)), "query issued but not awaiting")
    `ASSERT_IMPL(a_failed_quiet, r_failed,
        !r_awaiting && !r_pending, "failed round still active")
    `ASSERT_NEXT(a_request_pends, in_acc && (i_in_word.cmd == CMD_REQUEST),
        r_pending && !r_failed, "request did not set pending")

endmodule
